### hdl/tlgf_pkg.sv
package tlgf_pkg;

  // Grid geometry.
  localparam int GRID_WIDTH  = 64;
  localparam int GRID_HEIGHT = 64;

  localparam int XW         = $clog2(GRID_WIDTH);
  localparam int YW         = $clog2(GRID_HEIGHT);
  localparam int AW         = XW + YW;
  localparam int CELL_DEPTH = 1 << AW;
  localparam int ROW_DEPTH  = 1 << YW;

  // Width of the coordinate fields on the request channel.
  localparam int COORD_W = 6;

  localparam logic [7:0] BRIGHT_FULL = 8'd255;
  localparam logic [7:0] HUE_STEP    = 8'd2;
  localparam logic [3:0] BIRTH_N     = 4'd3;
  localparam logic [3:0] SURV_MIN    = 4'd2;
  localparam logic [3:0] SURV_MAX    = 4'd3;

  // 0.9 * 2^16, rounded up; floor(b * FADE_MUL / 2^16) equals floor(9 * b / 10)
  // for every 8-bit b.
  localparam logic [23:0] FADE_MUL = 24'd58983;

  typedef logic [GRID_WIDTH-1:0] row_vec_t;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_STEP    = 2'd1,
    OP_READ    = 2'd2,
    OP_RESTART = 2'd3
  } op_t;

  typedef struct packed {
    logic       alive;
    logic [7:0] hue;
    logic [7:0] bright;
  } cell_t;

  typedef struct packed {
    logic [3:0] n;
    logic       prev;
  } nbr_t;

  typedef enum logic [1:0] {
    CW_ZERO,
    CW_LOAD,
    CW_EVOLVE
  } cell_wsel_t;

  typedef struct packed {
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    cell_wsel_t    wr_sel;
    logic [AW-1:0] wr_addr;
    logic          ld_alive;
    logic [7:0]    ld_hue;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    RW_ZERO,
    RW_SETBIT,
    RW_NEWROW
  } row_wsel_t;

  typedef enum logic [2:0] {
    RO_HOLD,
    RO_LD_ABOVE,
    RO_LD_CUR,
    RO_LD_BELOW,
    RO_SHIFT
  } row_op_t;

  typedef struct packed {
    logic [YW-1:0] rd_row;
    logic          wr_en;
    row_wsel_t     wr_sel;
    logic [YW-1:0] wr_row;
    logic [XW-1:0] bit_x;
    logic          bit_val;
    row_op_t       op;
    logic          below_wrap;
    logic          acc_en;
    logic [XW-1:0] acc_x;
  } row_ctl_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR,
    ST_RD,
    ST_A_L1,
    ST_A_L2,
    ST_A_L3,
    ST_A_CELL,
    ST_A_ROWEND,
    ST_A_SHIFT
  } state_t;

  function automatic logic [7:0] fade(input logic [7:0] b);
    logic [23:0] p;
    p = 24'(b) * FADE_MUL;
    return p[23:16];
  endfunction

endpackage

### hdl/tlgf_in_if.sv
interface tlgf_in_if;
  import tlgf_pkg::*;

  logic               valid;
  logic               ready;
  op_t                op;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;
  logic               alive_in;
  logic [7:0]         hue_in;

  modport source (output valid, op, col, row, alive_in, hue_in, input ready);
  modport sink   (input valid, op, col, row, alive_in, hue_in, output ready);
endinterface

### hdl/tlgf_out_if.sv
interface tlgf_out_if;
  logic       valid;
  logic       ready;
  logic       alive_out;
  logic [7:0] hue_out;
  logic [7:0] bright_out;
  logic [7:0] gen_count;

  modport source (output valid, alive_out, hue_out, bright_out, gen_count, input ready);
  modport sink   (input valid, alive_out, hue_out, bright_out, gen_count, output ready);
endinterface

### hdl/tlgf_row_unit.sv
module tlgf_row_unit (
  input  logic               clk,
  input  tlgf_pkg::row_ctl_t ctl,
  input  logic               alive_new,
  output tlgf_pkg::nbr_t     nbr
);
  import tlgf_pkg::*;

  // One word per grid row holding the live bits of that row.
  row_vec_t mem [ROW_DEPTH];

  row_vec_t q_r;
  row_vec_t above_r;
  row_vec_t cur_r;
  row_vec_t below_r;
  row_vec_t row0_r;
  row_vec_t new_row_r;
  row_vec_t new_row_c;
  row_vec_t wdata;

  logic [XW-1:0] xl;
  logic [XW-1:0] xr;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_row] <= wdata;
    end
    q_r <= mem[ctl.rd_row];
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      RO_LD_ABOVE: above_r <= q_r;
      RO_LD_CUR: begin
        cur_r  <= q_r;
        row0_r <= q_r;
      end
      RO_LD_BELOW: below_r <= q_r;
      RO_SHIFT: begin
        above_r <= cur_r;
        cur_r   <= below_r;
        below_r <= ctl.below_wrap ? row0_r : q_r;
      end
      default: ;
    endcase
    if (ctl.acc_en) begin
      new_row_r <= new_row_c;
    end
  end

  always_comb begin
    new_row_c = new_row_r;
    if (ctl.acc_en) begin
      new_row_c[ctl.acc_x] = alive_new;
    end
  end

  always_comb begin
    wdata = '0;
    case (ctl.wr_sel)
      RW_ZERO:   wdata = '0;
      RW_SETBIT: begin
        wdata = q_r;
        wdata[ctl.bit_x] = ctl.bit_val;
      end
      RW_NEWROW: wdata = new_row_c;
      default:   wdata = '0;
    endcase
  end

  // Neighbor count over the three buffered rows, wrapping at the row ends.
  always_comb begin
    xl = (ctl.acc_x == '0) ? XW'(GRID_WIDTH - 1) : ctl.acc_x - 1'b1;
    xr = (int'(ctl.acc_x) == GRID_WIDTH - 1) ? '0 : ctl.acc_x + 1'b1;
    nbr.n = 4'(above_r[xl]) + 4'(above_r[ctl.acc_x]) + 4'(above_r[xr]) +
            4'(cur_r[xl]) + 4'(cur_r[xr]) +
            4'(below_r[xl]) + 4'(below_r[ctl.acc_x]) + 4'(below_r[xr]);
    nbr.prev = cur_r[ctl.acc_x];
  end

endmodule

### hdl/tlgf_cell_unit.sv
module tlgf_cell_unit (
  input  logic                clk,
  input  tlgf_pkg::cell_ctl_t ctl,
  input  tlgf_pkg::nbr_t      nbr,
  output tlgf_pkg::cell_t     rd_q,
  output logic                alive_new
);
  import tlgf_pkg::*;

  cell_t mem [CELL_DEPTH];
  cell_t q_r;
  cell_t evolved;
  cell_t wdata;
  logic  born;
  logic  dies;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= wdata;
    end
    q_r <= mem[ctl.rd_addr];
  end

  assign rd_q = q_r;

  // Life rule applied to the cell whose data was read in the previous cycle.
  always_comb begin
    born = !nbr.prev && (nbr.n == BIRTH_N);
    dies = nbr.prev && ((nbr.n < SURV_MIN) || (nbr.n > SURV_MAX));
    alive_new = born || (nbr.prev && !dies);
    evolved.alive  = alive_new;
    evolved.hue    = born ? q_r.hue + HUE_STEP : q_r.hue;
    evolved.bright = born ? BRIGHT_FULL : (nbr.prev ? q_r.bright : fade(q_r.bright));
  end

  always_comb begin
    wdata = '0;
    case (ctl.wr_sel)
      CW_ZERO: wdata = '0;
      CW_LOAD: begin
        wdata.alive  = ctl.ld_alive;
        wdata.hue    = ctl.ld_alive ? ctl.ld_hue : 8'd0;
        wdata.bright = ctl.ld_alive ? BRIGHT_FULL : 8'd0;
      end
      CW_EVOLVE: wdata = evolved;
      default:   wdata = '0;
    endcase
  end

endmodule

### hdl/toroidal_life_grid_with_fade.sv
// Wrap-around Life grid with fading brightness, 64 x 64 cells.
// Requests arrive on in_ch (valid/ready); each carries an op, a cell position,
// a live bit and a hue. Every accepted request yields exactly one result on
// out_ch (valid/ready): the cell's live bit, hue and brightness for a read,
// zeros otherwise, and the generation count after the request.
// A restart loads its result as it is accepted; a cell write passes through
// ST_WR and a read through ST_RD first, and a generation step first fills
// the row buffers in ST_A_L1 to ST_A_L3. The step sweeps the cell memory once
// in raster order, one read and one write per cycle, while three row buffers
// taken from a row-wide live-bit memory supply the neighbor counts; each row
// ends in ST_A_ROWEND, and every row but the last then turns the row buffers
// over in ST_A_SHIFT. Restarts can be taken every cycle while the receiver
// takes each result as it is offered.
// One request is worked on at a time. A request is accepted only while the
// block is idle and the result register is empty or being emptied, so a
// stalled receiver holds off further requests but nothing is lost.
// After rst_n is released the block clears every cell, one address per cycle;
// in_ch.ready stays low during that pass.
module toroidal_life_grid_with_fade (
  input logic       clk,
  input logic       rst_n,
  tlgf_in_if.sink   in_ch,
  tlgf_out_if.source out_ch
);
  import tlgf_pkg::*;

  state_t        state_r, state_nxt;
  logic [7:0]    gen_r, gen_nxt;
  logic [XW-1:0] x_r, x_nxt;
  logic [YW-1:0] y_r, y_nxt;
  logic          pv_r, pv_nxt;
  logic [XW-1:0] px_r, px_nxt;
  logic [AW-1:0] clr_r, clr_nxt;

  // Held fields of a pending write or read.
  logic [XW-1:0] wr_x_r, wr_x_nxt;
  logic [YW-1:0] wr_y_r, wr_y_nxt;
  logic          wr_a_r, wr_a_nxt;
  logic          wr_in_r, wr_in_nxt;
  logic          rd_in_r, rd_in_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          out_alive_r;
  logic [7:0]    out_hue_r;
  logic [7:0]    out_bright_r;
  logic [7:0]    out_gen_r;

  logic          in_fire;
  logic          in_inside;
  logic [AW-1:0] in_addr;
  logic          load_out;
  logic          res_alive;
  logic [7:0]    res_hue;
  logic [7:0]    res_bright;

  cell_ctl_t     cell_ctl;
  row_ctl_t      row_ctl;
  nbr_t          nbr;
  cell_t         cell_q;
  logic          alive_new;

  tlgf_cell_unit u_cell (
    .clk       (clk),
    .ctl       (cell_ctl),
    .nbr       (nbr),
    .rd_q      (cell_q),
    .alive_new (alive_new)
  );

  tlgf_row_unit u_row (
    .clk       (clk),
    .ctl       (row_ctl),
    .alive_new (alive_new),
    .nbr       (nbr)
  );

  assign in_ch.ready       = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire           = in_ch.valid && in_ch.ready;
  assign in_inside         = (int'(in_ch.col) < GRID_WIDTH) && (int'(in_ch.row) < GRID_HEIGHT);
  assign in_addr           = {YW'(in_ch.row), XW'(in_ch.col)};

  assign out_ch.valid      = out_valid_r;
  assign out_ch.alive_out  = out_alive_r;
  assign out_ch.hue_out    = out_hue_r;
  assign out_ch.bright_out = out_bright_r;
  assign out_ch.gen_count  = out_gen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      gen_r       <= 8'd0;
      clr_r       <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gen_r       <= gen_nxt;
      clr_r       <= clr_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    px_r    <= px_nxt;
    wr_x_r  <= wr_x_nxt;
    wr_y_r  <= wr_y_nxt;
    wr_a_r  <= wr_a_nxt;
    wr_in_r <= wr_in_nxt;
    rd_in_r <= rd_in_nxt;
    if (load_out) begin
      out_alive_r  <= res_alive;
      out_hue_r    <= res_hue;
      out_bright_r <= res_bright;
      out_gen_r    <= gen_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    gen_nxt   = gen_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    pv_nxt    = pv_r;
    px_nxt    = px_r;
    clr_nxt   = clr_r;
    wr_x_nxt  = wr_x_r;
    wr_y_nxt  = wr_y_r;
    wr_a_nxt  = wr_a_r;
    wr_in_nxt = wr_in_r;
    rd_in_nxt = rd_in_r;

    load_out   = 1'b0;
    res_alive  = 1'b0;
    res_hue    = 8'd0;
    res_bright = 8'd0;

    cell_ctl.rd_addr  = {y_r, x_r};
    cell_ctl.wr_en    = 1'b0;
    cell_ctl.wr_sel   = CW_EVOLVE;
    cell_ctl.wr_addr  = {y_r, px_r};
    cell_ctl.ld_alive = in_ch.alive_in;
    cell_ctl.ld_hue   = in_ch.hue_in;

    row_ctl.rd_row     = y_r;
    row_ctl.wr_en      = 1'b0;
    row_ctl.wr_sel     = RW_NEWROW;
    row_ctl.wr_row     = y_r;
    row_ctl.bit_x      = wr_x_r;
    row_ctl.bit_val    = wr_a_r;
    row_ctl.op         = RO_HOLD;
    row_ctl.below_wrap = 1'b0;
    row_ctl.acc_en     = 1'b0;
    row_ctl.acc_x      = px_r;

    unique case (state_r)
      ST_CLEAR: begin
        // Zero one cell per cycle; the row memory is zeroed along the way.
        cell_ctl.wr_en   = 1'b1;
        cell_ctl.wr_sel  = CW_ZERO;
        cell_ctl.wr_addr = clr_r;
        row_ctl.wr_en    = 1'b1;
        row_ctl.wr_sel   = RW_ZERO;
        row_ctl.wr_row   = clr_r[AW-1:XW];
        clr_nxt          = clr_r + 1'b1;
        if (&clr_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cell_ctl.rd_addr = in_addr;
        row_ctl.rd_row   = (in_ch.op == OP_STEP) ? YW'(GRID_HEIGHT - 1) : YW'(in_ch.row);
        if (in_fire) begin
          unique case (in_ch.op)
            OP_WRITE: begin
              // Cell data is written now; the live-bit row is patched next cycle.
              cell_ctl.wr_en   = in_inside;
              cell_ctl.wr_sel  = CW_LOAD;
              cell_ctl.wr_addr = in_addr;
              wr_x_nxt         = XW'(in_ch.col);
              wr_y_nxt         = YW'(in_ch.row);
              wr_a_nxt         = in_ch.alive_in;
              wr_in_nxt        = in_inside;
              state_nxt        = ST_WR;
            end
            OP_STEP: begin
              state_nxt = ST_A_L1;
            end
            OP_READ: begin
              rd_in_nxt = in_inside;
              state_nxt = ST_RD;
            end
            OP_RESTART: begin
              gen_nxt  = 8'd0;
              load_out = 1'b1;
            end
          endcase
        end
      end
      ST_WR: begin
        row_ctl.wr_en  = wr_in_r;
        row_ctl.wr_sel = RW_SETBIT;
        row_ctl.wr_row = wr_y_r;
        load_out       = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_RD: begin
        load_out = 1'b1;
        if (rd_in_r) begin
          res_alive  = cell_q.alive;
          res_hue    = cell_q.hue;
          res_bright = cell_q.bright;
        end
        state_nxt = ST_IDLE;
      end
      ST_A_L1: begin
        // Last row arrives as the row above row 0.
        row_ctl.op     = RO_LD_ABOVE;
        row_ctl.rd_row = '0;
        state_nxt      = ST_A_L2;
      end
      ST_A_L2: begin
        row_ctl.op     = RO_LD_CUR;
        row_ctl.rd_row = YW'(1);
        state_nxt      = ST_A_L3;
      end
      ST_A_L3: begin
        row_ctl.op = RO_LD_BELOW;
        x_nxt      = '0;
        y_nxt      = '0;
        pv_nxt     = 1'b0;
        state_nxt  = ST_A_CELL;
      end
      ST_A_CELL: begin
        // Read cell x while the cell read last cycle is evolved and written.
        pv_nxt = 1'b1;
        px_nxt = x_r;
        if (pv_r) begin
          cell_ctl.wr_en = 1'b1;
          row_ctl.acc_en = 1'b1;
        end
        if (int'(x_r) == GRID_WIDTH - 1) begin
          state_nxt = ST_A_ROWEND;
        end else begin
          x_nxt = x_r + 1'b1;
        end
      end
      ST_A_ROWEND: begin
        // Finish the last cell of the row and store the row's new live bits.
        cell_ctl.wr_en = 1'b1;
        row_ctl.acc_en = 1'b1;
        row_ctl.wr_en  = 1'b1;
        row_ctl.wr_sel = RW_NEWROW;
        pv_nxt         = 1'b0;
        if (int'(y_r) == GRID_HEIGHT - 1) begin
          gen_nxt   = gen_r + 8'd1;
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          row_ctl.rd_row = YW'(int'(y_r) + 2);
          state_nxt      = ST_A_SHIFT;
        end
      end
      ST_A_SHIFT: begin
        // Row 0 has been overwritten by now, so its saved copy wraps in.
        row_ctl.op         = RO_SHIFT;
        row_ctl.below_wrap = (int'(y_r) + 2 == GRID_HEIGHT);
        y_nxt              = y_r + 1'b1;
        x_nxt              = '0;
        state_nxt          = ST_A_CELL;
      end
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // A waiting result is never overwritten by a new one.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !load_out)
    else $error("result register overwritten while stalled");

  // The clearing pass produces no results.
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !out_valid_r)
    else $error("result seen during clearing pass");

  // The row end always completes the last column of the row.
  a_rowend_col: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_A_ROWEND) |-> (pv_r && (int'(px_r) == GRID_WIDTH - 1)))
    else $error("row end reached without the last column pending");

  // Finishing the last row advances the generation count by one.
  a_gen_step: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_A_ROWEND) && (int'(y_r) == GRID_HEIGHT - 1))
      |=> (gen_r == $past(gen_r) + 8'd1) && (out_gen_r == gen_r))
    else $error("generation count not advanced after a step");

endmodule

### tb/sv/toroidal_life_grid_with_fade_test.sv
`timescale 1ns / 1ps

module toroidal_life_grid_with_fade_test;
  import tlgf_pkg::*;

  // One result from the grid: the read cell's contents and the generation count.
  typedef struct packed {
    logic       alive;
    logic [7:0] hue;
    logic [7:0] bright;
    logic [7:0] gen;
  } cell_report_t;

  // One line of the directed script. When pinned is set, the result is the one
  // typed into the line; otherwise the grid model works it out.
  typedef struct packed {
    op_t                op;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               alive;
    logic [7:0]         hue;
    bit                 pinned;
    cell_report_t       report;
  } script_line_t;

  localparam cell_report_t NO_CELL   = '0;
  localparam cell_report_t FULL_CELL = '{1'b1, 8'hFF, 8'hFF, 8'd0};
  localparam cell_report_t LIVE_DARK = '{1'b1, 8'h00, 8'hFF, 8'd0};

  localparam int SCRIPT_LEN = 23;

  // The opening script walks a few corners of the behavior. The corner cells
  // test the wrap at both ends of each coordinate, and a blinker laid across
  // the left/right seam exercises births and deaths that see neighbors on the
  // far side of the grid. The cell at column 63 of row 1 starts with hue 0xFE,
  // so its rebirth two generations later wraps the hue past 255 to zero. The
  // isolated cell at the far corner dies of loneliness, keeps its brightness
  // for one generation, and then fades to nine tenths of it each generation.
  localparam script_line_t SCRIPT [SCRIPT_LEN] = '{
    '{OP_READ,    6'd0,  6'd0,  1'b0, 8'h00, 1'b1, NO_CELL},
    '{OP_READ,    6'd63, 6'd63, 1'b1, 8'hFF, 1'b1, NO_CELL},
    '{OP_WRITE,   6'd63, 6'd63, 1'b1, 8'hFF, 1'b1, NO_CELL},
    '{OP_READ,    6'd63, 6'd63, 1'b0, 8'h00, 1'b1, FULL_CELL},
    '{OP_WRITE,   6'd0,  6'd0,  1'b1, 8'h00, 1'b1, NO_CELL},
    '{OP_READ,    6'd0,  6'd0,  1'b0, 8'h00, 1'b1, LIVE_DARK},
    '{OP_WRITE,   6'd0,  6'd0,  1'b0, 8'hAA, 1'b1, NO_CELL},
    '{OP_READ,    6'd0,  6'd0,  1'b0, 8'h00, 1'b1, NO_CELL},
    '{OP_WRITE,   6'd63, 6'd1,  1'b1, 8'hFE, 1'b1, NO_CELL},
    '{OP_WRITE,   6'd0,  6'd1,  1'b1, 8'h55, 1'b1, NO_CELL},
    '{OP_WRITE,   6'd1,  6'd1,  1'b1, 8'h2A, 1'b1, NO_CELL},
    '{OP_STEP,    6'd21, 6'd42, 1'b1, 8'h33, 1'b0, NO_CELL},
    '{OP_READ,    6'd0,  6'd0,  1'b0, 8'h00, 1'b0, NO_CELL},
    '{OP_READ,    6'd63, 6'd1,  1'b0, 8'h00, 1'b0, NO_CELL},
    '{OP_READ,    6'd63, 6'd63, 1'b0, 8'h00, 1'b0, NO_CELL},
    '{OP_STEP,    6'd0,  6'd0,  1'b0, 8'h00, 1'b0, NO_CELL},
    '{OP_READ,    6'd63, 6'd1,  1'b0, 8'h00, 1'b0, NO_CELL},
    '{OP_READ,    6'd63, 6'd63, 1'b0, 8'h00, 1'b0, NO_CELL},
    '{OP_RESTART, 6'd42, 6'd21, 1'b1, 8'hCC, 1'b1, NO_CELL},
    '{OP_READ,    6'd0,  6'd1,  1'b0, 8'h00, 1'b0, NO_CELL},
    '{OP_STEP,    6'd0,  6'd0,  1'b0, 8'h00, 1'b0, NO_CELL},
    '{OP_READ,    6'd63, 6'd63, 1'b0, 8'h00, 1'b0, NO_CELL},
    '{OP_WRITE,   6'd32, 6'd31, 1'b0, 8'h55, 1'b0, NO_CELL}
  };

  logic clk;
  logic rst_n;

  tlgf_in_if  in_ch ();
  tlgf_out_if out_ch ();

  toroidal_life_grid_with_fade u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // The grid model. Reset is applied only once, at the start of the run, so the
  // zero start value of these bit arrays doubles as the model's reset.
  bit       grid_alive  [GRID_HEIGHT][GRID_WIDTH];
  bit       grid_prev   [GRID_HEIGHT][GRID_WIDTH];
  bit [7:0] grid_hue    [GRID_HEIGHT][GRID_WIDTH];
  bit [7:0] grid_bright [GRID_HEIGHT][GRID_WIDTH];
  bit [7:0] gen_model;

  // Results still owed by the block, oldest first.
  cell_report_t pending_reports[$];

  int err_count;
  int src_idle_pct;
  int sink_stall_pct;
  // Cycles for which the receiver refuses results; set by the stimulus and
  // counted down by the receiver process.
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Applies one accepted request to the grid model and returns the result that
  // the block must give for it.
  function automatic cell_report_t apply_request(input op_t op,
                                                 input logic [COORD_W-1:0] col,
                                                 input logic [COORD_W-1:0] row,
                                                 input logic alive,
                                                 input logic [7:0] hue);
    cell_report_t rep;
    int           n;
    int           y;
    int           x;
    int           dy;
    int           dx;
    rep = '0;
    case (op)
      OP_WRITE: begin
        grid_alive[row][col]  = alive;
        grid_prev[row][col]   = alive;
        grid_hue[row][col]    = alive ? hue : 8'd0;
        grid_bright[row][col] = alive ? 8'd255 : 8'd0;
      end
      OP_STEP: begin
        // Neighbor counts come from the previous-generation bits only, which
        // stay untouched until the whole sweep is done.
        for (y = 0; y < GRID_HEIGHT; y++) begin
          for (x = 0; x < GRID_WIDTH; x++) begin
            n = 0;
            for (dy = -1; dy <= 1; dy++) begin
              for (dx = -1; dx <= 1; dx++) begin
                if (dy != 0 || dx != 0) begin
                  n += grid_prev[(y + dy + GRID_HEIGHT) % GRID_HEIGHT]
                                [(x + dx + GRID_WIDTH) % GRID_WIDTH];
                end
              end
            end
            if (!grid_prev[y][x] && grid_bright[y][x] != 0) begin
              grid_bright[y][x] = 8'((9 * int'(grid_bright[y][x])) / 10);
            end
            if (n == 3 && !grid_prev[y][x]) begin
              grid_alive[y][x]  = 1'b1;
              grid_hue[y][x]    = grid_hue[y][x] + 8'd2;
              grid_bright[y][x] = 8'd255;
            end else if (grid_prev[y][x] && (n < 2 || n > 3)) begin
              grid_alive[y][x] = 1'b0;
            end
          end
        end
        grid_prev = grid_alive;
        gen_model = gen_model + 8'd1;
      end
      OP_READ: begin
        rep.alive  = grid_alive[row][col];
        rep.hue    = grid_hue[row][col];
        rep.bright = grid_bright[row][col];
      end
      default: begin
        gen_model = 8'd0;
      end
    endcase
    rep.gen = gen_model;
    return rep;
  endfunction

  // Offers one request, with a random idle gap first, and records the result
  // owed for it once the block has accepted it. Returns at the accepting edge.
  task automatic send_request(input op_t op,
                              input logic [COORD_W-1:0] col,
                              input logic [COORD_W-1:0] row,
                              input logic alive,
                              input logic [7:0] hue,
                              input bit pinned,
                              input cell_report_t pinned_report);
    cell_report_t rep;
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.op       <= op;
    in_ch.col      <= col;
    in_ch.row      <= row;
    in_ch.alive_in <= alive;
    in_ch.hue_in   <= hue;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    rep = apply_request(op, col, row, alive, hue);
    pending_reports.push_back(pinned ? pinned_report : rep);
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  // Receiver: refuses results while a hold is running, otherwise stalls at
  // random at the rate of the current phase.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Every accepted result is matched against the oldest owed one.
  always @(posedge clk) begin : check_results
    cell_report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_reports.size() == 0) begin
        $error({"result with no request waiting: alive_out %0d, hue_out %0d, ",
                "bright_out %0d, gen_count %0d"},
               out_ch.alive_out, out_ch.hue_out, out_ch.bright_out, out_ch.gen_count);
        err_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("alive_out", 8'(want.alive), 8'(out_ch.alive_out));
        check_field("hue_out", want.hue, out_ch.hue_out);
        check_field("bright_out", want.bright, out_ch.bright_out);
        check_field("gen_count", want.gen, out_ch.gen_count);
      end
    end
  end

  initial begin
    int i;
    int j;
    int phase;
    int phase_items;
    int bx;
    int by;
    int count;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.op       = OP_WRITE;
    in_ch.col      = '0;
    in_ch.row      = '0;
    in_ch.alive_in = 1'b0;
    in_ch.hue_in   = 8'd0;
    err_count      = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_cycles    = 0;
    gen_model      = 8'd0;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // The block clears its cell memory after reset; the first request simply
    // waits for ready to come up.
    for (i = 0; i < SCRIPT_LEN; i++) begin
      send_request(SCRIPT[i].op, SCRIPT[i].col, SCRIPT[i].row, SCRIPT[i].alive,
                   SCRIPT[i].hue, SCRIPT[i].pinned, SCRIPT[i].report);
    end

    // Back-pressure: the receiver refuses results for a long stretch while
    // requests keep coming, so the result register fills and the block has to
    // hold off its input.
    hold_cycles = 150;
    for (i = 0; i < 10; i++) begin
      send_request((i % 2 == 0) ? OP_WRITE : OP_READ, 6'($urandom_range(63)),
                   6'($urandom_range(63)), 1'($urandom_range(1)),
                   8'($urandom_range(255)), 1'b0, NO_CELL);
    end

    // Random part, in four idling phases. Most of it is small patterns written
    // into a 4 x 4 window at a random place (often straddling a seam), evolved
    // one or two generations, and then read back around the window so that
    // births, deaths and fading cells show up. The rest is noise: any op at any
    // place with any payload.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 84; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 84; end
        default: begin src_idle_pct = 36; sink_stall_pct = 36; end
      endcase
      phase_items = 0;
      while (phase_items < 24) begin
        if ($urandom_range(99) < 20) begin
          send_request(op_t'($urandom_range(3)), 6'($urandom_range(63)),
                       6'($urandom_range(63)), 1'($urandom_range(1)),
                       8'($urandom_range(255)), 1'b0, NO_CELL);
          phase_items++;
        end else begin
          bx    = $urandom_range(63);
          by    = $urandom_range(63);
          count = $urandom_range(6, 2);
          for (j = 0; j < count; j++) begin
            send_request(OP_WRITE, 6'(bx + $urandom_range(3)), 6'(by + $urandom_range(3)),
                         1'($urandom_range(3) != 0), 8'($urandom_range(255)),
                         1'b0, NO_CELL);
          end
          phase_items += count;
          count = ($urandom_range(3) == 0) ? 2 : 1;
          for (j = 0; j < count; j++) begin
            send_request(OP_STEP, 6'($urandom_range(63)), 6'($urandom_range(63)),
                         1'($urandom_range(1)), 8'($urandom_range(255)), 1'b0, NO_CELL);
          end
          phase_items += count;
          count = $urandom_range(5, 2);
          for (j = 0; j < count; j++) begin
            send_request(OP_READ, 6'(bx + $urandom_range(4) - 1),
                         6'(by + $urandom_range(4) - 1), 1'($urandom_range(1)),
                         8'($urandom_range(255)), 1'b0, NO_CELL);
          end
          phase_items += count;
          if ($urandom_range(9) == 0) begin
            send_request(OP_RESTART, 6'($urandom_range(63)), 6'($urandom_range(63)),
                         1'($urandom_range(1)), 8'($urandom_range(255)), 1'b0, NO_CELL);
            phase_items++;
          end
        end
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    sink_stall_pct = 0;
    while (pending_reports.size() != 0) @(posedge clk);
    // A stray extra result after the last one would show up in this wait.
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: even with every request a generation step and the worst stalls,
  // a correct run ends well before this.
  initial begin
    #50_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
